// ----- rtl/fua_pkg.sv -----
// Shared types and constants for the H.264 FU-A packetizer.
// No dependencies; used by every module of the block.
`default_nettype none

package fua_pkg;

	localparam int BYTE_W = 8;
	localparam int MP_W   = 13;
	localparam int SEQ_W  = 16;
	localparam int NAL_LEN_W = 20;

	localparam logic [MP_W-1:0] MAX_PAYLOAD_RST = 13'd1400;
	localparam logic [MP_W-1:0] MAX_PAYLOAD_MIN = 13'd2;

	localparam logic [BYTE_W-1:0] FU_A_TYPE = 8'd28;
	localparam logic [BYTE_W-1:0] NRI_MASK  = 8'h60;
	localparam logic [BYTE_W-1:0] TYPE_MASK = 8'h1F;
	localparam logic [BYTE_W-1:0] S_BIT     = 8'h80;
	localparam logic [BYTE_W-1:0] E_BIT     = 8'h40;

	// result count per beat: none, one, three
	localparam logic [1:0] CNT_NONE  = 2'd0;
	localparam logic [1:0] CNT_ONE   = 2'd1;
	localparam logic [1:0] CNT_THREE = 2'd3;

	typedef struct packed {
		logic [BYTE_W-1:0] data;
		logic              pkt_start;
		logic              pkt_end;
		logic              frag;
	} res_t;

	typedef struct packed {
		logic [1:0]       cnt;
		logic [SEQ_W-1:0] seq;
		res_t [2:0]       r;
	} bundle_t;

endpackage

`default_nettype wire

// ----- rtl/fua_step.sv -----
// Packetizer state and per-beat result logic: one NAL byte in, up to three
// payload results out as a bundle. Depends on fua_pkg.
`default_nettype none

module fua_step #(
	parameter int LENGTH_BITS = 20
) (
	input  wire                           clk,
	input  wire                           arst_n,
	input  wire                           adv,
	input  wire [fua_pkg::BYTE_W-1:0]     nal_byte,
	input  wire                           first_of_nal,
	input  wire [fua_pkg::NAL_LEN_W-1:0]  nal_length,
	input  wire [fua_pkg::MP_W-1:0]       mp,
	output fua_pkg::bundle_t              bundle
);

	localparam int CW = (LENGTH_BITS > fua_pkg::MP_W) ? LENGTH_BITS : fua_pkg::MP_W;

	logic                         frag_q, frag_n;
	logic [fua_pkg::BYTE_W-1:0]   held_q, held_n;
	logic [LENGTH_BITS-1:0]       br_q, br_n;
	logic [fua_pkg::MP_W-1:0]     bip_q, bip_n;
	logic                         ffp_q, ffp_n;
	logic [fua_pkg::SEQ_W-1:0]    seq_q;
	logic                         seq_inc;

	logic [LENGTH_BITS-1:0]       len_raw, len;
	logic [CW-1:0]                mp_ext;
	logic [fua_pkg::MP_W-1:0]     bip_inc;
	logic [fua_pkg::BYTE_W-1:0]   fu_hdr;
	logic                         pkt_done;

	assign len_raw = LENGTH_BITS'(nal_length);
	assign len     = (len_raw == '0) ? LENGTH_BITS'(1) : len_raw;
	assign mp_ext  = CW'(mp);
	assign bip_inc = bip_q + fua_pkg::MP_W'(1);

	always_comb begin
		frag_n  = frag_q;
		held_n  = held_q;
		br_n    = br_q;
		bip_n   = bip_q;
		ffp_n   = ffp_q;
		seq_inc = 1'b0;
		fu_hdr  = '0;
		pkt_done = 1'b0;
		bundle.cnt = fua_pkg::CNT_NONE;
		bundle.seq = seq_q;
		bundle.r   = '0;

		if (first_of_nal) begin
			bip_n = '0;
			br_n  = len - LENGTH_BITS'(1);
			if (CW'(len) <= mp_ext) begin
				frag_n  = 1'b0;
				ffp_n   = 1'b0;
				seq_inc = (br_n == '0);
				bundle.cnt  = fua_pkg::CNT_ONE;
				bundle.r[0] = '{data: nal_byte, pkt_start: 1'b1, pkt_end: seq_inc,
					frag: 1'b0};
			end else begin
				// header byte held back, rebuilt as FU indicator/header later
				frag_n = 1'b1;
				held_n = nal_byte;
				ffp_n  = 1'b1;
			end
		end else if (br_q != '0) begin
			br_n = br_q - LENGTH_BITS'(1);
			if (!frag_q) begin
				seq_inc = (br_n == '0);
				bundle.cnt  = fua_pkg::CNT_ONE;
				bundle.r[0] = '{data: nal_byte, pkt_start: 1'b0, pkt_end: seq_inc,
					frag: 1'b0};
			end else begin
				pkt_done = (br_n == '0) || (bip_inc >= mp);
				bip_n    = pkt_done ? '0 : bip_inc;
				seq_inc  = pkt_done;
				if (bip_q == '0) begin
					fu_hdr = (held_q & fua_pkg::TYPE_MASK)
						| (ffp_q ? fua_pkg::S_BIT : '0)
						| ((CW'(br_q) <= mp_ext) ? fua_pkg::E_BIT : '0);
					ffp_n = 1'b0;
					bundle.cnt  = fua_pkg::CNT_THREE;
					bundle.r[0] = '{data: (held_q & fua_pkg::NRI_MASK) | fua_pkg::FU_A_TYPE,
						pkt_start: 1'b1, pkt_end: 1'b0, frag: 1'b1};
					bundle.r[1] = '{data: fu_hdr, pkt_start: 1'b0, pkt_end: 1'b0,
						frag: 1'b1};
					bundle.r[2] = '{data: nal_byte, pkt_start: 1'b0, pkt_end: pkt_done,
						frag: 1'b1};
				end else begin
					bundle.cnt  = fua_pkg::CNT_ONE;
					bundle.r[0] = '{data: nal_byte, pkt_start: 1'b0, pkt_end: pkt_done,
						frag: 1'b1};
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frag_q <= 1'b0;
			held_q <= '0;
			br_q   <= '0;
			bip_q  <= '0;
			ffp_q  <= 1'b0;
			seq_q  <= '0;
		end else if (adv) begin
			frag_q <= frag_n;
			held_q <= held_n;
			br_q   <= br_n;
			bip_q  <= bip_n;
			ffp_q  <= ffp_n;
			if (seq_inc) begin
				seq_q <= seq_q + fua_pkg::SEQ_W'(1);
			end
		end
	end

endmodule

`default_nettype wire

// ----- rtl/fua_outq.sv -----
// Result register: holds one beat's bundle and hands its results out one
// per cycle on the payload channel while pay_ready is high. Depends on fua_pkg.
`default_nettype none

module fua_outq (
	input  wire                        clk,
	input  wire                        arst_n,
	input  wire                        load,
	input  fua_pkg::bundle_t           bundle,
	output logic                       free,
	output logic                       pay_valid,
	input  wire                        pay_ready,
	output logic [fua_pkg::BYTE_W-1:0] payload_byte,
	output logic                       packet_start,
	output logic                       packet_end,
	output logic                       fragmented,
	output logic [fua_pkg::SEQ_W-1:0]  sequence_number,
	output logic                       last_of_run
);

	fua_pkg::bundle_t bundle_s2;
	logic             valid_q;
	logic [1:0]       idx_q;
	logic             last;
	fua_pkg::res_t    cur;

	assign last = (idx_q == bundle_s2.cnt - 2'd1);
	assign free = !valid_q || (pay_ready && last);
	assign cur  = bundle_s2.r[idx_q];

	assign pay_valid       = valid_q;
	assign payload_byte    = cur.data;
	assign packet_start    = cur.pkt_start;
	assign packet_end      = cur.pkt_end;
	assign fragmented      = cur.frag;
	assign sequence_number = bundle_s2.seq;
	assign last_of_run     = last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q   <= '0;
		end else if (load) begin
			valid_q <= 1'b1;
			idx_q   <= '0;
		end else if (valid_q && pay_ready) begin
			if (last) begin
				valid_q <= 1'b0;
			end else begin
				idx_q <= idx_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			bundle_s2 <= bundle;
		end
	end

`ifndef SYNTHESIS
	a_idx_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q |-> (bundle_s2.cnt != fua_pkg::CNT_NONE) && (idx_q < bundle_s2.cnt))
		else $error("result index beyond bundle count");

	a_fu_open: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q && (bundle_s2.cnt == fua_pkg::CNT_THREE) && (idx_q == 2'd0)
		|-> packet_start && fragmented && !packet_end)
		else $error("three-result beat does not open an FU-A packet");

	a_run_holds: assert property (@(posedge clk) disable iff (!arst_n)
		pay_valid && pay_ready && !last_of_run |=> pay_valid && $stable(sequence_number))
		else $error("run of results broken before its last beat");
`endif

endmodule

`default_nettype wire

// ----- rtl/h264_nal_rtp_fu_a_packetizer.sv -----
// A NAL byte taken is held in the input register; its results are then loaded
// into the result register, which presents them on the payload channel.
// Throughput: one byte per cycle while each byte yields one result and pay_ready
// is high; a byte that opens an FU-A fragment yields three results, which the
// result register serializes, stalling nal_ready meanwhile.
// Reset (arst_n low, asynchronous): all control state cleared, max_payload 1400.
// Depends on fua_pkg, fua_step, fua_outq.
`default_nettype none

module h264_nal_rtp_fu_a_packetizer #(
	parameter int LENGTH_BITS = 20
) (
	input  wire                           clk,
	input  wire                           arst_n,
	input  wire                           cfg_we,
	input  wire [fua_pkg::MP_W-1:0]       cfg_data,
	input  wire                           nal_valid,
	output logic                          nal_ready,
	input  wire [fua_pkg::BYTE_W-1:0]     nal_byte,
	input  wire                           first_of_nal,
	input  wire [fua_pkg::NAL_LEN_W-1:0]  nal_length,
	output logic                          pay_valid,
	input  wire                           pay_ready,
	output logic [fua_pkg::BYTE_W-1:0]    payload_byte,
	output logic                          packet_start,
	output logic                          packet_end,
	output logic                          fragmented,
	output logic [fua_pkg::SEQ_W-1:0]     sequence_number,
	output logic                          last_of_run
);

	logic [fua_pkg::MP_W-1:0]      max_payload_q;
	logic [fua_pkg::MP_W-1:0]      mp;

	logic                          valid_s1;
	logic [fua_pkg::BYTE_W-1:0]    byte_s1;
	logic                          first_s1;
	logic [fua_pkg::NAL_LEN_W-1:0] len_s1;

	fua_pkg::bundle_t              bundle;
	logic                          outq_free;
	logic                          adv;

	assign mp = (max_payload_q < fua_pkg::MAX_PAYLOAD_MIN) ? fua_pkg::MAX_PAYLOAD_MIN
		: max_payload_q;

	// beats with no result only touch state, so they never wait on the output
	assign adv       = valid_s1 && ((bundle.cnt == fua_pkg::CNT_NONE) || outq_free);
	assign nal_ready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_payload_q <= fua_pkg::MAX_PAYLOAD_RST;
		end else if (cfg_we) begin
			max_payload_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (nal_ready) begin
			valid_s1 <= nal_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (nal_ready && nal_valid) begin
			byte_s1  <= nal_byte;
			first_s1 <= first_of_nal;
			len_s1   <= nal_length;
		end
	end

	fua_step #(
		.LENGTH_BITS (LENGTH_BITS)
	) u_step (
		.clk          (clk),
		.arst_n       (arst_n),
		.adv          (adv),
		.nal_byte     (byte_s1),
		.first_of_nal (first_s1),
		.nal_length   (len_s1),
		.mp           (mp),
		.bundle       (bundle)
	);

	fua_outq u_outq (
		.clk             (clk),
		.arst_n          (arst_n),
		.load            (adv && (bundle.cnt != fua_pkg::CNT_NONE)),
		.bundle          (bundle),
		.free            (outq_free),
		.pay_valid       (pay_valid),
		.pay_ready       (pay_ready),
		.payload_byte    (payload_byte),
		.packet_start    (packet_start),
		.packet_end      (packet_end),
		.fragmented      (fragmented),
		.sequence_number (sequence_number),
		.last_of_run     (last_of_run)
	);

endmodule

`default_nettype wire

// ----- tb/fua_payload_checker.sv -----
`timescale 1ns / 100ps
// Checker for the H.264 FU-A packetizer: follows NAL beats and max_payload
// writes, predicts every payload beat and compares them in order.
// Depends on fua_pkg.

module fua_payload_checker (
	input  wire                           clk,
	input  wire                           arst_n,
	input  wire                           cfg_we,
	input  wire [fua_pkg::MP_W-1:0]       cfg_data,
	input  wire                           nal_valid,
	input  wire                           nal_ready,
	input  wire [fua_pkg::BYTE_W-1:0]     nal_byte,
	input  wire                           first_of_nal,
	input  wire [fua_pkg::NAL_LEN_W-1:0]  nal_length,
	input  wire                           pay_valid,
	input  wire                           pay_ready,
	input  wire [fua_pkg::BYTE_W-1:0]     payload_byte,
	input  wire                           packet_start,
	input  wire                           packet_end,
	input  wire                           fragmented,
	input  wire [fua_pkg::SEQ_W-1:0]      sequence_number,
	input  wire                           last_of_run,
	output int                            fail_count,
	output int                            outstanding
);

	typedef struct packed {
		logic [fua_pkg::BYTE_W-1:0] data;
		logic                       pkt_start;
		logic                       pkt_end;
		logic                       frag;
		logic [fua_pkg::SEQ_W-1:0]  seq;
		logic                       last;
	} payload_t;

	payload_t payload_due [$];

	logic [fua_pkg::MP_W-1:0]      mp_reg;
	logic                          frag_mode;
	logic [fua_pkg::BYTE_W-1:0]    held_hdr;
	logic [fua_pkg::NAL_LEN_W-1:0] remaining;
	logic [fua_pkg::MP_W-1:0]      body_cnt;
	logic                          start_due;
	logic [fua_pkg::SEQ_W-1:0]     seq_ctr;

	function automatic payload_t beat_of(input logic [fua_pkg::BYTE_W-1:0] d,
			input logic s, input logic e, input logic f);
		payload_t p;
		p.data = d;
		p.pkt_start = s;
		p.pkt_end = e;
		p.frag = f;
		p.seq = seq_ctr;
		p.last = 1'b0;
		return p;
	endfunction

	function automatic string show(input payload_t p);
		return $sformatf("byte %02h start %0d end %0d frag %0d seq %0d last %0d",
			p.data, p.pkt_start, p.pkt_end, p.frag, p.seq, p.last);
	endfunction

	// One NAL beat in, up to three payload beats queued.
	function automatic void packetize_byte(input logic [fua_pkg::BYTE_W-1:0] b,
			input logic f, input logic [fua_pkg::NAL_LEN_W-1:0] l);
		payload_t                      run [0:2];
		int                            n;
		logic [fua_pkg::MP_W-1:0]      mp;
		logic [fua_pkg::NAL_LEN_W-1:0] len;
		logic [fua_pkg::BYTE_W-1:0]    fu_hdr;
		logic                          end_pkt;
		n = 0;
		mp = (mp_reg < fua_pkg::MAX_PAYLOAD_MIN) ? fua_pkg::MAX_PAYLOAD_MIN : mp_reg;
		if (f) begin
			len = (l == '0) ? fua_pkg::NAL_LEN_W'(1) : l;
			body_cnt = '0;
			remaining = len - fua_pkg::NAL_LEN_W'(1);
			if (len <= fua_pkg::NAL_LEN_W'(mp)) begin
				frag_mode = 1'b0;
				start_due = 1'b0;
				run[n] = beat_of(b, 1'b1, remaining == '0, 1'b0);
				n++;
				if (remaining == '0)
					seq_ctr++;
			end else begin
				// header is held for the FU indicator and FU header
				frag_mode = 1'b1;
				held_hdr = b;
				start_due = 1'b1;
			end
		end else if (remaining != '0) begin
			if (!frag_mode) begin
				remaining--;
				run[n] = beat_of(b, 1'b0, remaining == '0, 1'b0);
				n++;
				if (remaining == '0)
					seq_ctr++;
			end else begin
				if (body_cnt == '0) begin
					fu_hdr = held_hdr & fua_pkg::TYPE_MASK;
					if (start_due)
						fu_hdr = fu_hdr | fua_pkg::S_BIT;
					if (remaining <= fua_pkg::NAL_LEN_W'(mp))
						fu_hdr = fu_hdr | fua_pkg::E_BIT;
					start_due = 1'b0;
					run[n] = beat_of((held_hdr & fua_pkg::NRI_MASK) | fua_pkg::FU_A_TYPE,
						1'b1, 1'b0, 1'b1);
					n++;
					run[n] = beat_of(fu_hdr, 1'b0, 1'b0, 1'b1);
					n++;
				end
				remaining--;
				body_cnt++;
				end_pkt = (remaining == '0) || (body_cnt >= mp);
				run[n] = beat_of(b, 1'b0, end_pkt, 1'b1);
				n++;
				if (end_pkt) begin
					body_cnt = '0;
					seq_ctr++;
				end
			end
		end
		if (n > 0)
			run[n-1].last = 1'b1;
		for (int i = 0; i < n; i++)
			payload_due.push_back(run[i]);
	endfunction

	task automatic log_fail(input string msg);
		fail_count++;
		if (fail_count <= 10)
			$display("%0t: %s", $time, msg);
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		payload_t got;
		payload_t want;
		if (!arst_n) begin
			mp_reg = fua_pkg::MAX_PAYLOAD_RST;
			frag_mode = 1'b0;
			held_hdr = '0;
			remaining = '0;
			body_cnt = '0;
			start_due = 1'b0;
			seq_ctr = '0;
			fail_count = 0;
			payload_due.delete();
		end else begin
			if (cfg_we)
				mp_reg = cfg_data;
			if (nal_valid && nal_ready)
				packetize_byte(nal_byte, first_of_nal, nal_length);
			if (pay_valid && pay_ready) begin
				got.data = payload_byte;
				got.pkt_start = packet_start;
				got.pkt_end = packet_end;
				got.frag = fragmented;
				got.seq = sequence_number;
				got.last = last_of_run;
				if (payload_due.size() == 0) begin
					log_fail($sformatf("payload beat with none expected: %s", show(got)));
				end else begin
					want = payload_due.pop_front();
					if (got !== want)
						log_fail($sformatf("payload beat: expected %s, got %s",
							show(want), show(got)));
				end
			end
		end
		outstanding = payload_due.size();
	end

endmodule

// ----- tb/tb_h264_nal_rtp_fu_a_packetizer.sv -----
`timescale 1ns / 100ps
// Top of the FU-A packetizer testbench: clock, reset, NAL stimulus, max_payload
// phases and verdict. Depends on fua_pkg, the packetizer and fua_payload_checker.

module tb_h264_nal_rtp_fu_a_packetizer;

	logic                          clk;
	logic                          arst_n;
	logic                          cfg_we;
	logic [fua_pkg::MP_W-1:0]      cfg_data;
	logic                          nal_valid;
	logic                          nal_ready;
	logic [fua_pkg::BYTE_W-1:0]    nal_byte;
	logic                          first_of_nal;
	logic [fua_pkg::NAL_LEN_W-1:0] nal_length;
	logic                          pay_valid;
	logic                          pay_ready;
	logic [fua_pkg::BYTE_W-1:0]    payload_byte;
	logic                          packet_start;
	logic                          packet_end;
	logic                          fragmented;
	logic [fua_pkg::SEQ_W-1:0]     sequence_number;
	logic                          last_of_run;

	int fail_count;
	int outstanding;
	int gap_pct = 0;
	int stall_pct = 0;
	int beats = 0;
	int cur_mp = 1400;
	int mp_plan [8] = '{2, 5, 8191, 4, 4096, 1, 8, 3};

	h264_nal_rtp_fu_a_packetizer i_dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_we          (cfg_we),
		.cfg_data        (cfg_data),
		.nal_valid       (nal_valid),
		.nal_ready       (nal_ready),
		.nal_byte        (nal_byte),
		.first_of_nal    (first_of_nal),
		.nal_length      (nal_length),
		.pay_valid       (pay_valid),
		.pay_ready       (pay_ready),
		.payload_byte    (payload_byte),
		.packet_start    (packet_start),
		.packet_end      (packet_end),
		.fragmented      (fragmented),
		.sequence_number (sequence_number),
		.last_of_run     (last_of_run)
	);

	fua_payload_checker i_checker (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_we          (cfg_we),
		.cfg_data        (cfg_data),
		.nal_valid       (nal_valid),
		.nal_ready       (nal_ready),
		.nal_byte        (nal_byte),
		.first_of_nal    (first_of_nal),
		.nal_length      (nal_length),
		.pay_valid       (pay_valid),
		.pay_ready       (pay_ready),
		.payload_byte    (payload_byte),
		.packet_start    (packet_start),
		.packet_end      (packet_end),
		.fragmented      (fragmented),
		.sequence_number (sequence_number),
		.last_of_run     (last_of_run),
		.fail_count      (fail_count),
		.outstanding     (outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	always @(negedge clk) begin
		pay_ready <= ($urandom_range(0, 99) >= stall_pct);
	end

	task automatic set_mode(input int m);
		case (m)
			0: begin gap_pct = 0;  stall_pct = 0;  end
			1: begin gap_pct = 71; stall_pct = 0;  end
			2: begin gap_pct = 0;  stall_pct = 71; end
			default: begin gap_pct = 33; stall_pct = 33; end
		endcase
	endtask

	// one NAL beat; returns at the edge that takes it
	task automatic put_beat(input logic [fua_pkg::BYTE_W-1:0] b, input logic f,
			input logic [fua_pkg::NAL_LEN_W-1:0] l);
		@(negedge clk);
		while ($urandom_range(0, 99) < gap_pct) begin
			nal_valid = 1'b0;
			@(negedge clk);
		end
		nal_valid = 1'b1;
		nal_byte = b;
		first_of_nal = f;
		nal_length = l;
		do @(posedge clk); while (!nal_ready);
	endtask

	task automatic put_stray;
		put_beat(fua_pkg::BYTE_W'($urandom_range(0, 255)), 1'b0,
			fua_pkg::NAL_LEN_W'($urandom_range(0, 20'hFFFFF)));
	endtask

	task automatic send_nal(input logic [fua_pkg::BYTE_W-1:0] hdr,
			input logic [fua_pkg::NAL_LEN_W-1:0] len, input int nbody);
		put_beat(hdr, 1'b1, len);
		for (int i = 0; i < nbody; i++)
			put_stray;
		beats += nbody + 1;
	endtask

	// drain, then allow for a held header still in the pipe
	task automatic wait_idle;
		@(negedge clk);
		nal_valid = 1'b0;
		while (outstanding != 0)
			@(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	task automatic write_mp(input int v);
		@(negedge clk);
		cfg_we = 1'b1;
		cfg_data = v[fua_pkg::MP_W-1:0];
		@(negedge clk);
		cfg_we = 1'b0;
		cur_mp = v;
	endtask

	initial begin
		int   kind;
		int   len;
		int   eff;
		int   quota;
		logic nal_open;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_data = '0;
		nal_valid = 1'b0;
		nal_byte = '0;
		first_of_nal = 1'b0;
		nal_length = '0;
		pay_ready = 1'b0;
		nal_open = 1'b0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: reset max_payload of 1400 first
		set_mode(3);
		put_beat(8'hFF, 1'b0, 20'hFFFFF);    // no NAL open: dropped
		send_nal(8'h00, 20'd0, 0);           // zero length counts as one
		send_nal(8'hFF, 20'd1, 0);
		send_nal(8'h65, 20'd2, 1);
		send_nal(8'h7C, 20'hFFFFF, 3);       // fragment left open
		send_nal(8'h41, 20'd2, 1);           // abandons it
		wait_idle;
		write_mp(0);                         // clamps to 2
		send_nal(8'hE5, 20'd3, 2);           // lone fragment, S and E
		send_nal(8'h1F, 20'd5, 4);
		wait_idle;
		write_mp(3);
		send_nal(8'h5C, 20'd6, 2);
		wait_idle;
		write_mp(1);                         // shrinks mid-NAL
		for (int i = 0; i < 3; i++)
			put_stray;
		beats += 3;

		beats = 0;
		for (int p = 0; p < 8; p++) begin
			wait_idle;
			write_mp(mp_plan[p]);
			set_mode(p % 4);
			quota = beats + 11;
			while (beats < quota) begin
				kind = $urandom_range(0, 9);
				eff = (cur_mp < 2) ? 2 : cur_mp;
				if (kind == 0 && !nal_open) begin
					put_stray;
				end else if (kind == 1) begin
					send_nal(fua_pkg::BYTE_W'($urandom_range(0, 255)),
						fua_pkg::NAL_LEN_W'($urandom_range(30, 20'hFFFFF)),
						$urandom_range(0, 4));
					nal_open = 1'b1;
				end else begin
					if (kind < 4 && eff <= 30)
						len = eff + $urandom_range(0, 1);
					else
						len = $urandom_range(0, 24);
					send_nal(fua_pkg::BYTE_W'($urandom_range(0, 255)),
						fua_pkg::NAL_LEN_W'(len), (len == 0) ? 0 : len - 1);
					nal_open = 1'b0;
				end
			end
		end

		wait_idle;
		if (fail_count == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

	initial begin
		#2000000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
